[src/ple_pkg.sv]
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// ple_pkg
// shared constants, request codes, controller states and port bundles of
// the palette lookup engine
// ----------------------------------------------------------------------------
package ple_pkg;

    localparam int PAL_ENTRIES = 256;
    localparam int IDX_W       = (PAL_ENTRIES > 1) ? $clog2(PAL_ENTRIES) : 1;
    localparam int CH_W        = 8;
    localparam int RGB_W       = 3 * CH_W;
    localparam int FAC_W       = 9;
    localparam int ACC_W       = 2 * CH_W;
    localparam int STEP_W      = 3;

    localparam logic [FAC_W-1:0]  BLEND_ONE = FAC_W'(256);
    localparam logic [STEP_W-1:0] MAC_LAST  = STEP_W'(5);

    typedef enum logic [1:0] {
        REQ_WRITE  = 2'd0,
        REQ_LOOKUP = 2'd1,
        REQ_SEARCH = 2'd2,
        REQ_BLEND  = 2'd3
    } req_t;

    typedef enum logic [3:0] {
        ST_IDLE,
        ST_FWD_RD,
        ST_FWD_OUT,
        ST_SRCH,
        ST_BLD_RDA,
        ST_BLD_RDB,
        ST_BLD_CAPB,
        ST_BLD_MAC
    } state_t;

    typedef struct packed {
        logic             wr_en;
        logic [IDX_W-1:0] wr_addr;
        logic [RGB_W-1:0] wr_data;
        logic             rd_en;
        logic [IDX_W-1:0] rd_addr;
    } ram_req_t;

    typedef struct packed {
        logic en;
        logic first;
    } mac_ctrl_t;

endpackage

[src/ple_palette_ram.sv]
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// ple_palette_ram
// palette storage, one write and one registered read per cycle; per-entry
// valid flags make never-written entries read as zero after reset
// ----------------------------------------------------------------------------
module ple_palette_ram
(
    input  logic                    clk,
    input  logic                    rst_n,
    input  ple_pkg::ram_req_t       req,
    output logic [ple_pkg::RGB_W-1:0] rd_data
);

    logic [ple_pkg::RGB_W-1:0]       mem [ple_pkg::PAL_ENTRIES];
    logic [ple_pkg::PAL_ENTRIES-1:0] valid_reg;
    logic [ple_pkg::RGB_W-1:0]       rd_mem_reg;
    logic                            rd_valid_reg;

    always_ff @(posedge clk)
    begin
        if (req.wr_en)
        begin
            mem[req.wr_addr] <= req.wr_data;
        end
        if (req.rd_en)
        begin
            rd_mem_reg <= mem[req.rd_addr];
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            valid_reg    <= '0;
            rd_valid_reg <= 1'b0;
        end
        else
        begin
            if (req.wr_en)
            begin
                valid_reg[req.wr_addr] <= 1'b1;
            end
            if (req.rd_en)
            begin
                rd_valid_reg <= valid_reg[req.rd_addr];
            end
        end
    end

    assign rd_data = rd_valid_reg ? rd_mem_reg : '0;

endmodule

[src/ple_mac_unit.sv]
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// ple_mac_unit
// shared multiply-accumulate: one 9x8 product per cycle, summed into an
// accumulator that restarts on the first term of each channel
// ----------------------------------------------------------------------------
module ple_mac_unit
(
    input  logic                       clk,
    input  ple_pkg::mac_ctrl_t         ctrl,
    input  logic [ple_pkg::FAC_W-1:0]  weight,
    input  logic [ple_pkg::CH_W-1:0]   operand,
    output logic [ple_pkg::ACC_W-1:0]  sum
);

    logic [ple_pkg::ACC_W-1:0]              acc_reg;
    logic [ple_pkg::FAC_W+ple_pkg::CH_W-1:0] product;

    // blend terms never exceed 256*255, so the sum fits the accumulator
    assign product = weight * operand;
    assign sum     = (ctrl.first ? '0 : acc_reg) + product[ple_pkg::ACC_W-1:0];

    always_ff @(posedge clk)
    begin
        if (ctrl.en)
        begin
            acc_reg <= sum;
        end
    end

endmodule

[src/palette_lookup_engine.sv]
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// palette_lookup_engine
// 256-entry 24-bit rgb palette with write, forward lookup, reverse search
// and two-entry interpolation
// ----------------------------------------------------------------------------
// One request at a time: a request is taken when start is high and busy is
// low, and busy stays high until its result is out. A write keeps busy low
// and gives no result. A forward lookup reads the palette and then gives
// its result beat; an interpolation gives it after two palette reads and six
// passes through the single shared multiply-accumulate unit, two per
// channel; a reverse search reads one palette entry per cycle from the top
// index down to index 1 through the single read port and stops at a match.
// The result beat is on color_rgb and pen_index for exactly one cycle
// with done high; it cannot be held off, so the receiver must take it then.
// Reset clears the palette at once through per-entry valid flags.
// ----------------------------------------------------------------------------
module palette_lookup_engine
(
    input  logic        clk,
    input  logic        rst_n,
    input  logic        start,
    output logic        busy,
    input  logic [1:0]  req_type,
    input  logic [7:0]  index_a,
    input  logic [7:0]  index_b,
    input  logic [7:0]  red_in,
    input  logic [7:0]  green_in,
    input  logic [7:0]  blue_in,
    input  logic [8:0]  blend_factor,
    output logic        done,
    output logic [23:0] color_rgb,
    output logic [7:0]  pen_index
);

    ple_pkg::state_t state_reg, state_next;

    logic                            accept;
    ple_pkg::req_t                   req_in;
    logic [ple_pkg::RGB_W-1:0]       rgb_in;
    logic                            in_rng_a;
    logic                            in_rng_b;

    logic [ple_pkg::IDX_W-1:0]       idx_a_reg;
    logic [ple_pkg::IDX_W-1:0]       idx_b_reg;
    logic                            rng_a_reg;
    logic                            rng_b_reg;
    logic [ple_pkg::RGB_W-1:0]       key_reg;
    logic [ple_pkg::FAC_W-1:0]       fac_reg;

    logic [ple_pkg::IDX_W-1:0]       scan_reg, scan_next;
    logic                            cmp_vld_reg, cmp_vld_next;
    logic [ple_pkg::IDX_W-1:0]       cmp_idx_reg, cmp_idx_next;

    logic [ple_pkg::RGB_W-1:0]       ca_reg, ca_next;
    logic [ple_pkg::RGB_W-1:0]       cb_reg, cb_next;
    logic [ple_pkg::STEP_W-1:0]      step_reg, step_next;
    logic [ple_pkg::CH_W-1:0]        bl_r_reg, bl_r_next;
    logic [ple_pkg::CH_W-1:0]        bl_g_reg, bl_g_next;

    logic                            done_reg, done_next;
    logic [23:0]                     color_reg, color_next;
    logic [7:0]                      pen_reg, pen_next;

    ple_pkg::ram_req_t               ram_req;
    logic [ple_pkg::RGB_W-1:0]       rd_data;

    ple_pkg::mac_ctrl_t              mac_ctrl;
    logic [ple_pkg::FAC_W-1:0]       mac_weight;
    logic [ple_pkg::CH_W-1:0]        mac_operand;
    logic [ple_pkg::ACC_W-1:0]       mac_sum;
    logic [ple_pkg::CH_W-1:0]        ch_a;
    logic [ple_pkg::CH_W-1:0]        ch_b;

    assign busy     = (state_reg != ple_pkg::ST_IDLE);
    assign accept   = start && !busy;
    assign req_in   = ple_pkg::req_t'(req_type);
    assign rgb_in   = {red_in, green_in, blue_in};
    assign in_rng_a = (int'(index_a) < ple_pkg::PAL_ENTRIES);
    assign in_rng_b = (int'(index_b) < ple_pkg::PAL_ENTRIES);

    assign done      = done_reg;
    assign color_rgb = color_reg;
    assign pen_index = pen_reg;

    ple_palette_ram u_ram
    (
        .clk     (clk),
        .rst_n   (rst_n),
        .req     (ram_req),
        .rd_data (rd_data)
    );

    ple_mac_unit u_mac
    (
        .clk     (clk),
        .ctrl    (mac_ctrl),
        .weight  (mac_weight),
        .operand (mac_operand),
        .sum     (mac_sum)
    );

    // channel picked for the current blend step
    always_comb
    begin
        unique case (step_reg[2:1])
            2'd0:
            begin
                ch_a = ca_reg[23:16];
                ch_b = cb_reg[23:16];
            end
            2'd1:
            begin
                ch_a = ca_reg[15:8];
                ch_b = cb_reg[15:8];
            end
            default:
            begin
                ch_a = ca_reg[7:0];
                ch_b = cb_reg[7:0];
            end
        endcase
    end

    assign mac_weight  = step_reg[0] ? fac_reg : (ple_pkg::BLEND_ONE - fac_reg);
    assign mac_operand = step_reg[0] ? ch_b : ch_a;

    // next state
    always_comb
    begin
        state_next = state_reg;
        unique case (state_reg)
            ple_pkg::ST_IDLE:
            begin
                if (accept)
                begin
                    unique case (req_in)
                        ple_pkg::REQ_WRITE:  state_next = ple_pkg::ST_IDLE;
                        ple_pkg::REQ_LOOKUP: state_next = ple_pkg::ST_FWD_RD;
                        ple_pkg::REQ_SEARCH: state_next = ple_pkg::ST_SRCH;
                        default:             state_next = ple_pkg::ST_BLD_RDA;
                    endcase
                end
            end
            ple_pkg::ST_FWD_RD:   state_next = ple_pkg::ST_FWD_OUT;
            ple_pkg::ST_FWD_OUT:  state_next = ple_pkg::ST_IDLE;
            ple_pkg::ST_SRCH:
            begin
                if (cmp_vld_reg && ((rd_data == key_reg) ||
                                    (cmp_idx_reg == ple_pkg::IDX_W'(1))))
                begin
                    state_next = ple_pkg::ST_IDLE;
                end
            end
            ple_pkg::ST_BLD_RDA:  state_next = ple_pkg::ST_BLD_RDB;
            ple_pkg::ST_BLD_RDB:  state_next = ple_pkg::ST_BLD_CAPB;
            ple_pkg::ST_BLD_CAPB: state_next = ple_pkg::ST_BLD_MAC;
            ple_pkg::ST_BLD_MAC:
            begin
                if (step_reg == ple_pkg::MAC_LAST)
                begin
                    state_next = ple_pkg::ST_IDLE;
                end
            end
            default:              state_next = ple_pkg::ST_IDLE;
        endcase
    end

    // datapath control and result
    always_comb
    begin
        ram_req         = '0;
        ram_req.wr_addr = index_a[ple_pkg::IDX_W-1:0];
        ram_req.wr_data = rgb_in;
        mac_ctrl        = '0;
        scan_next       = scan_reg;
        cmp_vld_next    = 1'b0;
        cmp_idx_next    = cmp_idx_reg;
        ca_next         = ca_reg;
        cb_next         = cb_reg;
        step_next       = step_reg;
        bl_r_next       = bl_r_reg;
        bl_g_next       = bl_g_reg;
        done_next       = 1'b0;
        color_next      = color_reg;
        pen_next        = pen_reg;

        unique case (state_reg)
            ple_pkg::ST_IDLE:
            begin
                ram_req.wr_en = accept && (req_in == ple_pkg::REQ_WRITE) && in_rng_a;
                scan_next     = ple_pkg::IDX_W'(ple_pkg::PAL_ENTRIES - 1);
                step_next     = '0;
            end
            ple_pkg::ST_FWD_RD:
            begin
                ram_req.rd_en   = 1'b1;
                ram_req.rd_addr = idx_a_reg;
            end
            ple_pkg::ST_FWD_OUT:
            begin
                done_next  = 1'b1;
                color_next = rng_a_reg ? rd_data : '0;
                pen_next   = '0;
            end
            ple_pkg::ST_SRCH:
            begin
                ram_req.rd_en   = 1'b1;
                ram_req.rd_addr = scan_reg;
                scan_next       = scan_reg - ple_pkg::IDX_W'(1);
                cmp_vld_next    = 1'b1;
                cmp_idx_next    = scan_reg;
                if (cmp_vld_reg && (rd_data == key_reg))
                begin
                    done_next  = 1'b1;
                    color_next = '0;
                    pen_next   = 8'(cmp_idx_reg);
                end
                else if (cmp_vld_reg && (cmp_idx_reg == ple_pkg::IDX_W'(1)))
                begin
                    done_next  = 1'b1;
                    color_next = '0;
                    pen_next   = '0;
                end
            end
            ple_pkg::ST_BLD_RDA:
            begin
                ram_req.rd_en   = 1'b1;
                ram_req.rd_addr = idx_a_reg;
            end
            ple_pkg::ST_BLD_RDB:
            begin
                ram_req.rd_en   = 1'b1;
                ram_req.rd_addr = idx_b_reg;
                ca_next         = rng_a_reg ? rd_data : '0;
            end
            ple_pkg::ST_BLD_CAPB:
            begin
                cb_next = rng_b_reg ? rd_data : '0;
            end
            ple_pkg::ST_BLD_MAC:
            begin
                mac_ctrl.en    = 1'b1;
                mac_ctrl.first = !step_reg[0];
                step_next      = step_reg + ple_pkg::STEP_W'(1);
                if (step_reg == ple_pkg::STEP_W'(1))
                begin
                    bl_r_next = mac_sum[ple_pkg::ACC_W-1:ple_pkg::CH_W];
                end
                if (step_reg == ple_pkg::STEP_W'(3))
                begin
                    bl_g_next = mac_sum[ple_pkg::ACC_W-1:ple_pkg::CH_W];
                end
                if (step_reg == ple_pkg::MAC_LAST)
                begin
                    done_next  = 1'b1;
                    color_next = {bl_r_reg, bl_g_reg,
                                  mac_sum[ple_pkg::ACC_W-1:ple_pkg::CH_W]};
                    pen_next   = '0;
                end
            end
            default:
            begin
                done_next = 1'b0;
            end
        endcase
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg   <= ple_pkg::ST_IDLE;
            done_reg    <= 1'b0;
            cmp_vld_reg <= 1'b0;
            step_reg    <= '0;
            scan_reg    <= '0;
        end
        else
        begin
            state_reg   <= state_next;
            done_reg    <= done_next;
            cmp_vld_reg <= cmp_vld_next;
            step_reg    <= step_next;
            scan_reg    <= scan_next;
        end
    end

    always_ff @(posedge clk)
    begin
        if (accept)
        begin
            idx_a_reg <= index_a[ple_pkg::IDX_W-1:0];
            idx_b_reg <= index_b[ple_pkg::IDX_W-1:0];
            rng_a_reg <= in_rng_a;
            rng_b_reg <= in_rng_b;
            key_reg   <= rgb_in;
            fac_reg   <= (blend_factor > ple_pkg::BLEND_ONE) ? ple_pkg::BLEND_ONE
                                                             : blend_factor;
        end
        cmp_idx_reg <= cmp_idx_next;
        ca_reg      <= ca_next;
        cb_reg      <= cb_next;
        bl_r_reg    <= bl_r_next;
        bl_g_reg    <= bl_g_next;
        color_reg   <= color_next;
        pen_reg     <= pen_next;
    end

endmodule
